FILE: rtl/core/drs_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the disk request scheduler
package drs_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int TRACK_WIDTH_DEF = 16;
	localparam int ID_W            = 16;
	localparam int TRACK_FIELD_W   = 16;
	localparam int STATUS_W        = 2;
	localparam int POLICY_W        = 3;

	localparam logic [POLICY_W-1:0] POL_FIFO  = 3'd0;
	localparam logic [POLICY_W-1:0] POL_SSTF  = 3'd1;
	localparam logic [POLICY_W-1:0] POL_LOOK  = 3'd2;
	localparam logic [POLICY_W-1:0] POL_CLOOK = 3'd3;
	localparam logic [POLICY_W-1:0] POL_FLOOK = 3'd4;

	typedef enum logic [STATUS_W-1:0] {
		STAT_ADDED,
		STAT_DROPPED,
		STAT_GRANTED,
		STAT_EMPTY
	} status_t;

	typedef enum logic [1:0] {
		SIDE_ANY,
		SIDE_UP,
		SIDE_DOWN
	} side_t;

	typedef enum logic [2:0] {
		PASS_FIFO,
		PASS_SSTF,
		PASS_FL_ANY,
		PASS_LOOK1,
		PASS_LOOK2,
		PASS_CUP,
		PASS_CLOW
	} pass_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_SCAN_END,
		S_SHIFT,
		S_DONE
	} state_t;

	typedef struct packed {
		side_t side;
		logic  ref_zero;
		logic  only_active;
		logic  active_set;
		logic  fifo_mode;
	} scan_ctrl_t;

endpackage

FILE: rtl/core/drs_store.sv
`timescale 1ns / 1ps
// request store memory: one write port, one registered read port
module drs_store #(
	parameter int DEPTH = drs_pkg::QUEUE_DEPTH_DEF,
	parameter int TW    = drs_pkg::TRACK_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [drs_pkg::ID_W-1:0] wr_id,
	input  logic [TW-1:0]            wr_track,
	input  logic                     wr_set,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [drs_pkg::ID_W-1:0] rd_id,
	output logic [TW-1:0]            rd_track,
	output logic                     rd_set
);
	import drs_pkg::*;

	localparam int EW = ID_W + TW + 1;

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_set, wr_track, wr_id};
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_id    = rd_q[ID_W-1:0];
	assign rd_track = rd_q[ID_W +: TW];
	assign rd_set   = rd_q[EW-1];

endmodule

FILE: rtl/core/drs_scan.sv
`timescale 1ns / 1ps
// shared seek distance compare unit that tracks the best candidate of a pass
module drs_scan #(
	parameter int TW = drs_pkg::TRACK_WIDTH_DEF,
	parameter int AW = 6
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clr,
	input  logic                     valid,
	input  drs_pkg::scan_ctrl_t      ctrl,
	input  logic [TW-1:0]            head,
	input  logic [AW-1:0]            idx,
	input  logic [TW-1:0]            track,
	input  logic                     set,
	input  logic [drs_pkg::ID_W-1:0] id,
	output logic                     found,
	output logic [AW-1:0]            best_idx,
	output logic [drs_pkg::ID_W-1:0] best_id,
	output logic [TW-1:0]            best_track
);
	import drs_pkg::*;

	logic          found_q;
	logic [AW-1:0] best_idx_q;
	logic [ID_W-1:0] best_id_q;
	logic [TW-1:0] best_track_q;
	logic [TW-1:0] best_dist_q;
	logic [TW-1:0] ref_pos;
	logic [TW-1:0] seek_d;
	logic          qual;
	logic          take;

	always_comb begin
		ref_pos = ctrl.ref_zero ? '0 : head;
		qual = 1'b1;
		if (ctrl.only_active && (set != ctrl.active_set)) begin
			qual = 1'b0;
		end
		if ((ctrl.side == SIDE_UP) && (track < head)) begin
			qual = 1'b0;
		end
		if ((ctrl.side == SIDE_DOWN) && (track > head)) begin
			qual = 1'b0;
		end
		if (ctrl.fifo_mode) begin
			seek_d = '0;
		end else if (ref_pos > track) begin
			seek_d = ref_pos - track;
		end else begin
			seek_d = track - ref_pos;
		end
		take = valid && qual && (!found_q || (seek_d < best_dist_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clr) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q   <= idx;
			best_id_q    <= id;
			best_track_q <= track;
			best_dist_q  <= seek_d;
		end
	end

	assign found      = found_q;
	assign best_idx   = best_idx_q;
	assign best_id    = best_id_q;
	assign best_track = best_track_q;

endmodule

FILE: rtl/core/disk_request_scheduler_core.sv
`timescale 1ns / 1ps
// disk request scheduler top level: sequencer, policy register and result register
// Holds up to QUEUE_DEPTH pending requests in arrival order in a single-port-read
// memory and serves fetches by fifo, shortest seek, look, circular look or flook.
// An add goes through the decode and done states before the next accept. A fetch
// walks the stored entries through one distance comparator, one entry per cycle at
// the memory read port: fifo uses a one-entry pass, look and circular look may need
// two passes and flook up to three; the granted entry is then removed by moving the
// later entries down one slot, one per cycle. A new item is accepted while the
// previous result is still waiting in the output register.
module disk_request_scheduler_core #(
	parameter int QUEUE_DEPTH = drs_pkg::QUEUE_DEPTH_DEF,
	parameter int TRACK_WIDTH = drs_pkg::TRACK_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [drs_pkg::POLICY_W-1:0]      cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              command,
	input  logic [drs_pkg::ID_W-1:0]          req_id,
	input  logic [drs_pkg::TRACK_FIELD_W-1:0] request_track,
	input  logic [drs_pkg::TRACK_FIELD_W-1:0] head_track,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [drs_pkg::STATUS_W-1:0]      status,
	output logic [drs_pkg::ID_W-1:0]          granted_id,
	output logic [drs_pkg::TRACK_FIELD_W-1:0] granted_track
);
	import drs_pkg::*;

	localparam int TW = (TRACK_WIDTH < TRACK_FIELD_W) ? TRACK_WIDTH : TRACK_FIELD_W;
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	state_t             state_q, state_d;
	logic [POLICY_W-1:0] policy_q;
	pass_t              pass_q;
	logic               cmd_q;
	logic [ID_W-1:0]    id_q;
	logic [TW-1:0]      track_q;
	logic [TW-1:0]      head_q;
	logic [CW-1:0]      count_q;
	logic               active_q;
	logic               sweep_up_q;
	logic [CW-1:0]      ptr_q;
	logic               valid_s1;
	logic [AW-1:0]      idx_s1;
	status_t            res_status_q;
	logic [ID_W-1:0]    res_id_q;
	logic [TW-1:0]      res_track_q;
	logic               out_valid_q;
	status_t            out_status_q;
	logic [ID_W-1:0]    out_id_q;
	logic [TRACK_FIELD_W-1:0] out_track_q;

	logic               accept;
	logic               load_out;
	logic               room;
	logic [CW-1:0]      scan_len;
	logic               rd_en;
	logic               scan_clr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [ID_W-1:0]    wr_id;
	logic [TW-1:0]      wr_track;
	logic               wr_set;
	logic [ID_W-1:0]    rd_id;
	logic [TW-1:0]      rd_track;
	logic               rd_set;
	scan_ctrl_t         scan_ctrl;
	logic               found;
	logic [AW-1:0]      best_idx;
	logic [ID_W-1:0]    best_id;
	logic [TW-1:0]      best_track;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign load_out = (state_q == S_DONE) && (!out_valid_q || !out_stall);
	assign room     = (count_q < DEPTH_C);
	assign scan_len = (pass_q == PASS_FIFO) ? CW'(1) : count_q;

	drs_store #(
		.DEPTH (QUEUE_DEPTH),
		.TW    (TW)
	) u_store (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_id    (wr_id),
		.wr_track (wr_track),
		.wr_set   (wr_set),
		.rd_en    (rd_en),
		.rd_addr  (ptr_q[AW-1:0]),
		.rd_id    (rd_id),
		.rd_track (rd_track),
		.rd_set   (rd_set)
	);

	drs_scan #(
		.TW (TW),
		.AW (AW)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.clr        (scan_clr),
		.valid      (valid_s1 && (state_q == S_SCAN)),
		.ctrl       (scan_ctrl),
		.head       (head_q),
		.idx        (idx_s1),
		.track      (rd_track),
		.set        (rd_set),
		.id         (rd_id),
		.found      (found),
		.best_idx   (best_idx),
		.best_id    (best_id),
		.best_track (best_track)
	);

	always_comb begin
		scan_ctrl             = '0;
		scan_ctrl.side        = SIDE_ANY;
		scan_ctrl.active_set  = active_q;
		case (pass_q)
			PASS_FIFO: begin
				scan_ctrl.fifo_mode = 1'b1;
			end
			PASS_FL_ANY: begin
				scan_ctrl.only_active = 1'b1;
			end
			PASS_LOOK1, PASS_LOOK2: begin
				scan_ctrl.side        = sweep_up_q ? SIDE_UP : SIDE_DOWN;
				scan_ctrl.only_active = (policy_q == POL_FLOOK);
			end
			PASS_CUP: begin
				scan_ctrl.side = SIDE_UP;
			end
			PASS_CLOW: begin
				scan_ctrl.ref_zero = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		rd_en    = 1'b0;
		scan_clr = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = count_q[AW-1:0];
		wr_id    = id_q;
		wr_track = track_q;
		wr_set   = (policy_q == POL_FLOOK) ? ~active_q : active_q;
		case (state_q)
			S_DECODE: begin
				scan_clr = 1'b1;
				wr_en    = !cmd_q && room;
			end
			S_SCAN: begin
				rd_en = (ptr_q < scan_len);
			end
			S_SCAN_END: begin
				scan_clr = 1'b1;
			end
			S_SHIFT: begin
				rd_en = (ptr_q < count_q);
				if (valid_s1) begin
					wr_en    = 1'b1;
					wr_addr  = idx_s1 - AW'(1);
					wr_id    = rd_id;
					wr_track = rd_track;
					wr_set   = rd_set;
				end
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_DECODE;
			end
			S_DECODE: begin
				state_d = (cmd_q && (count_q != '0)) ? S_SCAN : S_DONE;
			end
			S_SCAN: begin
				if (!rd_en && !valid_s1) state_d = S_SCAN_END;
			end
			S_SCAN_END: begin
				case (pass_q)
					PASS_FL_ANY: state_d = S_SCAN;
					PASS_LOOK1, PASS_CUP: state_d = found ? S_SHIFT : S_SCAN;
					default: state_d = found ? S_SHIFT : S_DONE;
				endcase
			end
			S_SHIFT: begin
				if (!rd_en && !valid_s1) state_d = S_DONE;
			end
			S_DONE: begin
				if (load_out) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			policy_q    <= POL_FIFO;
			pass_q      <= PASS_FIFO;
			count_q     <= '0;
			active_q    <= 1'b0;
			sweep_up_q  <= 1'b1;
			ptr_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			valid_s1    <= rd_en;
			out_valid_q <= load_out || (out_valid_q && out_stall);
			if (cfg_wr_en) policy_q <= cfg_wr_data;
			if (rd_en) ptr_q <= ptr_q + CW'(1);
			case (state_q)
				S_DECODE: begin
					ptr_q <= '0;
					if (!cmd_q && room) count_q <= count_q + CW'(1);
					case (policy_q)
						POL_SSTF:  pass_q <= PASS_SSTF;
						POL_LOOK:  pass_q <= PASS_LOOK1;
						POL_CLOOK: pass_q <= PASS_CUP;
						POL_FLOOK: pass_q <= PASS_FL_ANY;
						default:   pass_q <= PASS_FIFO;
					endcase
				end
				S_SCAN_END: begin
					case (pass_q)
						PASS_FL_ANY: begin
							if (!found) active_q <= ~active_q;
							pass_q <= PASS_LOOK1;
							ptr_q  <= '0;
						end
						PASS_LOOK1: begin
							if (found) begin
								ptr_q <= CW'(best_idx) + CW'(1);
							end else begin
								sweep_up_q <= ~sweep_up_q;
								pass_q     <= PASS_LOOK2;
								ptr_q      <= '0;
							end
						end
						PASS_CUP: begin
							if (found) begin
								ptr_q <= CW'(best_idx) + CW'(1);
							end else begin
								pass_q <= PASS_CLOW;
								ptr_q  <= '0;
							end
						end
						default: begin
							if (found) ptr_q <= CW'(best_idx) + CW'(1);
						end
					endcase
				end
				S_SHIFT: begin
					if (state_d == S_DONE) count_q <= count_q - CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= command;
			id_q    <= req_id;
			track_q <= request_track[TW-1:0];
			head_q  <= head_track[TW-1:0];
		end
		if (rd_en) idx_s1 <= ptr_q[AW-1:0];
		case (state_q)
			S_DECODE: begin
				res_id_q    <= '0;
				res_track_q <= '0;
				if (cmd_q) begin
					res_status_q <= STAT_EMPTY;
				end else if (room) begin
					res_status_q <= STAT_ADDED;
				end else begin
					res_status_q <= STAT_DROPPED;
				end
			end
			S_SCAN_END: begin
				if (found) begin
					res_status_q <= STAT_GRANTED;
					res_id_q     <= best_id;
					res_track_q  <= best_track;
				end else begin
					res_status_q <= STAT_EMPTY;
					res_id_q     <= '0;
					res_track_q  <= '0;
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			out_status_q <= res_status_q;
			out_id_q     <= res_id_q;
			out_track_q  <= TRACK_FIELD_W'(res_track_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign granted_id    = out_id_q;
	assign granted_track = out_track_q;

endmodule

FILE: tb/disk_request_scheduler_core_tb.sv
`timescale 1ns / 1ps
// testbench for the disk request scheduler: queued driver, monitor and scheduling predictor
module disk_request_scheduler_core_tb;
	import drs_pkg::*;

	localparam int QDEPTH = QUEUE_DEPTH_DEF;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_PHASES = 14;
	localparam int PHASE_ITEMS = 90;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	localparam logic [POLICY_W-1:0] POL_RSV5 = 3'd5;
	localparam logic [POLICY_W-1:0] POL_RSV6 = 3'd6;
	localparam logic [POLICY_W-1:0] POL_RSV7 = 3'd7;

	typedef struct {
		logic        cmd;
		logic [15:0] rid;
		logic [15:0] rtrk;
		logic [15:0] hd;
		int          gap;
		bit          drain;
	} cmd_item_t;

	typedef struct {
		status_t     st;
		logic [15:0] id;
		logic [15:0] trk;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [POLICY_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = 1'b0;
	logic [ID_W-1:0] req_id = '0;
	logic [TRACK_FIELD_W-1:0] request_track = '0;
	logic [TRACK_FIELD_W-1:0] head_track = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0] granted_id;
	logic [TRACK_FIELD_W-1:0] granted_track;

	disk_request_scheduler_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.req_id       (req_id),
		.request_track(request_track),
		.head_track   (head_track),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.granted_id   (granted_id),
		.granted_track(granted_track)
	);

	always #10 clk = ~clk;

	// predicted store contents
	logic [15:0] q_trk [QDEPTH];
	logic [15:0] q_id [QDEPTH];
	logic q_set [QDEPTH];
	int q_count = 0;
	logic q_active = 1'b0;
	logic q_sweep_up = 1'b1;
	logic [POLICY_W-1:0] q_policy = POL_FIFO;

	cmd_item_t cmd_backlog[$];
	reply_t replies_due[$];
	cmd_item_t cur;
	bit have_item = 0;
	int gap_left = 0;
	bit in_took = 0;
	bit out_took = 0;
	bit calm = 1;
	bit rx_calm = 1;
	bit hold_req = 0;
	int hold_left = 0;
	int stall_left = 0;
	int errors = 0;
	int quiet_cycles = 0;

	function automatic int nearest(logic [15:0] hd, logic [15:0] rf, side_t sd, bit only_act);
		int best;
		int best_d;
		int d;
		best = -1;
		best_d = 0;
		for (int i = 0; i < q_count; i++) begin
			if (only_act && q_set[i] != q_active) continue;
			if (sd == SIDE_UP && q_trk[i] < hd) continue;
			if (sd == SIDE_DOWN && q_trk[i] > hd) continue;
			d = int'(rf) - int'(q_trk[i]);
			if (d < 0) d = -d;
			if (best < 0 || d < best_d) begin
				best = i;
				best_d = d;
			end
		end
		return best;
	endfunction

	function automatic int sweep_pick(logic [15:0] hd, bit only_act);
		side_t sd;
		int k;
		sd = q_sweep_up ? SIDE_UP : SIDE_DOWN;
		k = nearest(hd, hd, sd, only_act);
		if (k < 0) begin
			q_sweep_up = ~q_sweep_up;
			sd = q_sweep_up ? SIDE_UP : SIDE_DOWN;
			k = nearest(hd, hd, sd, only_act);
		end
		return k;
	endfunction

	function automatic reply_t schedule_step(logic cmd, logic [15:0] rid, logic [15:0] rtrk,
			logic [15:0] hd);
		reply_t r;
		int k;
		r.st = STAT_ADDED;
		r.id = '0;
		r.trk = '0;
		if (cmd == CMD_ADD) begin
			if (q_count >= QDEPTH) begin
				r.st = STAT_DROPPED;
			end else begin
				q_trk[q_count] = rtrk;
				q_id[q_count] = rid;
				q_set[q_count] = (q_policy == POL_FLOOK) ? ~q_active : q_active;
				q_count++;
			end
			return r;
		end
		if (q_count == 0) begin
			r.st = STAT_EMPTY;
			return r;
		end
		case (q_policy)
			POL_SSTF: k = nearest(hd, hd, SIDE_ANY, 0);
			POL_LOOK: k = sweep_pick(hd, 0);
			POL_CLOOK: begin
				k = nearest(hd, hd, SIDE_UP, 0);
				if (k < 0) k = nearest(hd, 16'd0, SIDE_ANY, 0);
			end
			POL_FLOOK: begin
				// active set empty: the sets swap
				if (nearest(hd, hd, SIDE_ANY, 1) < 0) q_active = ~q_active;
				k = sweep_pick(hd, 1);
			end
			default: k = 0;
		endcase
		if (k < 0) begin
			r.st = STAT_EMPTY;
			return r;
		end
		r.st = STAT_GRANTED;
		r.id = q_id[k];
		r.trk = q_trk[k];
		for (int i = k; i < q_count - 1; i++) begin
			q_trk[i] = q_trk[i + 1];
			q_id[i] = q_id[i + 1];
			q_set[i] = q_set[i + 1];
		end
		q_count--;
		return r;
	endfunction

	function automatic logic [15:0] pick_track(bit narrow);
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return narrow ? 16'($urandom_range(0, 31)) : 16'($urandom());
		endcase
	endfunction

	task automatic push_item(logic cmd, logic [15:0] rid, logic [15:0] rtrk, logic [15:0] hd,
			bit drain);
		cmd_item_t it;
		it.cmd = cmd;
		it.rid = rid;
		it.rtrk = rtrk;
		it.hd = hd;
		it.gap = calm ? 0 : $urandom_range(0, 16);
		it.drain = drain;
		cmd_backlog.insert(cmd_backlog.size(), it);
	endtask

	task automatic settle();
		do @(posedge clk); while (cmd_backlog.size() != 0 || have_item || replies_due.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_policy(logic [POLICY_W-1:0] value);
		settle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		q_policy = value;
	endtask

	// driver
	always @(negedge clk) begin
		logic nxt;
		nxt = 1'b0;
		if (arst_n) begin
			if (in_valid && in_took) have_item = 0;
			if (in_valid && !in_took) begin
				nxt = 1'b1;
			end else begin
				if (!have_item && cmd_backlog.size() != 0) begin
					cur = cmd_backlog[0];
					cmd_backlog.delete(0);
					have_item = 1;
					gap_left = cur.gap;
				end
				if (have_item) begin
					if (gap_left != 0) gap_left--;
					else if (!cur.drain || replies_due.size() == 0) nxt = 1'b1;
				end
			end
			in_valid <= nxt;
			if (nxt) begin
				command <= cur.cmd;
				req_id <= cur.rid;
				request_track <= cur.rtrk;
				head_track <= cur.hd;
			end
		end
	end

	// receiver stall
	always @(negedge clk) begin
		logic nxt;
		nxt = 1'b0;
		if (out_took) stall_left = rx_calm ? 0 : $urandom_range(0, 16);
		if (hold_req) begin
			hold_req = 0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			nxt = 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			nxt = 1'b1;
		end
		out_stall <= nxt;
	end

	// monitor
	always @(posedge clk) begin
		reply_t want;
		if (arst_n) begin
			in_took = in_valid && !in_stall;
			out_took = out_valid && !out_stall;
			if (out_took) begin
				if (replies_due.size() == 0) begin
					errors++;
					$display("%0t unexpected item status %0d id %0h track %0h", $time,
						status, granted_id, granted_track);
				end else begin
					want = replies_due[0];
					replies_due.delete(0);
					if (status !== want.st) begin
						errors++;
						$display("%0t status mismatch exp %0d got %0d", $time, want.st, status);
					end
					if (granted_id !== want.id) begin
						errors++;
						$display("%0t id mismatch exp %0h got %0h", $time, want.id, granted_id);
					end
					if (granted_track !== want.trk) begin
						errors++;
						$display("%0t track mismatch exp %0h got %0h", $time, want.trk,
							granted_track);
					end
				end
			end
			if (in_took)
				replies_due.insert(replies_due.size(),
					schedule_step(command, req_id, request_track, head_track));
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		logic [POLICY_W-1:0] plan [RANDOM_PHASES];
		int add_pct;
		int chunk;
		bit add_heavy;
		bit narrow;
		bit is_add;
		int n;
		plan = '{POL_SSTF, POL_LOOK, POL_CLOOK, POL_FLOOK, POL_FIFO, POL_FLOOK, POL_LOOK,
			POL_RSV5, POL_SSTF, POL_CLOOK, POL_FLOOK, POL_RSV6, POL_LOOK, POL_RSV7};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: fetch on empty, field extremes, fifo order
		write_policy(POL_FIFO);
		push_item(CMD_FETCH, 16'h0000, 16'h0000, 16'hFFFF, 0);
		push_item(CMD_ADD, 16'hFFFF, 16'h0000, 16'h0000, 0);
		push_item(CMD_ADD, 16'h0000, 16'hFFFF, 16'hFFFF, 0);
		push_item(CMD_ADD, 16'h0001, 16'h8000, 16'h0000, 0);
		push_item(CMD_FETCH, 16'h0000, 16'h0000, 16'h0000, 0);
		// shortest seek with a distance tie, queued entries kept across the change
		write_policy(POL_SSTF);
		push_item(CMD_ADD, 16'h0002, 16'd100, 16'h0000, 0);
		push_item(CMD_ADD, 16'h0003, 16'd300, 16'h0000, 0);
		push_item(CMD_FETCH, 16'h0000, 16'h0000, 16'd200, 0);
		push_item(CMD_FETCH, 16'h0000, 16'h0000, 16'd200, 0);
		push_item(CMD_FETCH, 16'h0000, 16'h0000, 16'hFFFF, 0);
		// look with a direction flip
		write_policy(POL_LOOK);
		push_item(CMD_ADD, 16'h0004, 16'd50, 16'h0000, 0);
		push_item(CMD_FETCH, 16'h0000, 16'h0000, 16'd100, 0);
		push_item(CMD_FETCH, 16'h0000, 16'h0000, 16'd100, 0);
		// circular look wrapping to the lowest track
		write_policy(POL_CLOOK);
		push_item(CMD_ADD, 16'h0005, 16'd10, 16'h0000, 0);
		push_item(CMD_ADD, 16'h0006, 16'd20, 16'h0000, 0);
		push_item(CMD_FETCH, 16'h0000, 16'h0000, 16'd30, 0);
		push_item(CMD_FETCH, 16'h0000, 16'h0000, 16'd0, 0);
		// flook set swap
		write_policy(POL_FLOOK);
		push_item(CMD_ADD, 16'h0007, 16'd7, 16'h0000, 0);
		push_item(CMD_ADD, 16'h0008, 16'd9, 16'h0000, 0);
		push_item(CMD_FETCH, 16'h0000, 16'h0000, 16'd8, 0);
		push_item(CMD_FETCH, 16'h0000, 16'h0000, 16'd8, 0);
		// unused code behaves as fifo
		write_policy(POL_RSV7);
		push_item(CMD_ADD, 16'h0009, 16'd1234, 16'h0000, 0);
		push_item(CMD_ADD, 16'h000A, 16'd5, 16'h0000, 0);
		push_item(CMD_FETCH, 16'h0000, 16'h0000, 16'd5, 0);

		// receiver holds off at the start, and the store is filled past full
		write_policy(POL_FIFO);
		hold_req = 1;
		for (int i = 0; i < 70; i++)
			push_item(CMD_ADD, 16'($urandom()), pick_track(0), 16'($urandom()), 0);
		for (int i = 0; i < 70; i++)
			push_item(CMD_FETCH, 16'($urandom()), 16'($urandom()), pick_track(0), i == 0);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			write_policy(plan[ph]);
			calm = (ph % 5 == 2);
			rx_calm = calm;
			add_pct = $urandom_range(35, 70);
			n = 0;
			while (n < PHASE_ITEMS) begin
				chunk = $urandom_range(1, 24);
				add_heavy = ($urandom_range(0, 99) < add_pct);
				narrow = ($urandom_range(0, 2) != 0);
				for (int j = 0; j < chunk && n < PHASE_ITEMS; j++) begin
					is_add = add_heavy ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 9) < 2);
					push_item(is_add ? CMD_ADD : CMD_FETCH, 16'($urandom()), pick_track(narrow),
						pick_track(narrow), $urandom_range(0, 49) == 0);
					n++;
				end
			end
		end

		do @(posedge clk); while (cmd_backlog.size() != 0 || have_item || replies_due.size() != 0);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: disk_request_scheduler_core.f
rtl/core/drs_pkg.sv
rtl/core/drs_store.sv
rtl/core/drs_scan.sv
rtl/core/disk_request_scheduler_core.sv
tb/disk_request_scheduler_core_tb.sv
